// ----- src/ibv_pkg.sv -----
// ----------------------------------------------------------------------------
// ibv_pkg: shared types and constants of the bounded integer vector engine
// Request codes, result status codes, field widths and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package ibv_pkg;

  // Default number of slots in the vector
  localparam int DEF_CAPACITY = 32;

  // Field widths of the request and result words
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int CNT_O_W  = 6;
  localparam int IDX_O_W  = 5;

  // Packed stream widths, padded to whole bytes
  localparam int IN_FIELDS_W  = VAL_W + POS_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CNT_O_W + IDX_O_W + VAL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND         = 3'd0,
    OP_INSERT_AT      = 3'd1,
    OP_INSERT_SORTED  = 3'd2,
    OP_DELETE_LAST    = 3'd3,
    OP_DELETE_SWAP    = 3'd4,
    OP_DELETE_ORDERED = 3'd5,
    OP_CLEAR          = 3'd6,
    OP_DUMP           = 3'd7
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } stat_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHR_START,
    ST_SHR,
    ST_INS_WR,
    ST_SRCH,
    ST_DEL_REM,
    ST_SHL,
    ST_SWP_REM,
    ST_SWP_WR,
    ST_LAST,
    ST_DUMP,
    ST_EMIT
  } state_e;

  // One result word
  typedef struct packed {
    stat_e                     status;
    logic [CNT_O_W-1:0]        count;
    logic [IDX_O_W-1:0]        index;
    logic signed [VAL_W-1:0]   element;
    logic                      last;
  } res_t;

endpackage : ibv_pkg

`default_nettype wire

// ----- src/ibv_mem.sv -----
// ----------------------------------------------------------------------------
// ibv_mem: element store
// One write port and one read port with registered read data. The read data
// holds its value until the next read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module ibv_mem #(
  parameter int DEPTH = ibv_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                wr_addr_i,
  input  wire logic signed [ibv_pkg::VAL_W-1:0] wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [AW-1:0]                rd_addr_i,
  output logic signed [ibv_pkg::VAL_W-1:0]  rd_data_o
);
  import ibv_pkg::*;

  logic signed [VAL_W-1:0] mem_q [DEPTH];
  logic signed [VAL_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : ibv_mem

`default_nettype wire

// ----- src/ibv_ctrl.sv -----
// ----------------------------------------------------------------------------
// ibv_ctrl: request sequencer; decodes requests and hands result words out
// Walks the store one slot per cycle (a dump only while the output is free)
// with a single pointer unit (shift right, search, shift left, dump).
// ----------------------------------------------------------------------------
`default_nettype none

module ibv_ctrl #(
  parameter int CAPACITY = ibv_pkg::DEF_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request side
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire ibv_pkg::op_e                      in_op_i,
  input  wire logic signed [ibv_pkg::VAL_W-1:0]  in_value_i,
  input  wire logic [ibv_pkg::POS_W-1:0]         in_position_i,
  // result side
  input  wire logic                              out_free_i,
  output logic                                   emit_o,
  output ibv_pkg::res_t                          res_o,
  // store port
  output logic                                   mem_we_o,
  output logic [AW-1:0]                          mem_wr_addr_o,
  output logic signed [ibv_pkg::VAL_W-1:0]       mem_wr_data_o,
  output logic                                   mem_rd_en_o,
  output logic [AW-1:0]                          mem_rd_addr_o,
  input  wire logic signed [ibv_pkg::VAL_W-1:0]  mem_rd_data_i
);
  import ibv_pkg::*;

  // Common width for position and count compares
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           ptr_q, ptr_d;
  logic [CW-1:0]           tgt_q, tgt_d;
  stat_e                   rstat_q, rstat_d;
  logic [AW-1:0]           ridx_q, ridx_d;
  logic signed [VAL_W-1:0] relem_q, relem_d;

  logic          full, empty, pos_over, pos_out, less;
  logic [XW-1:0] posx, cntx;
  logic [CW-1:0] ptr_up, ptr_up2, ptr_dn, ptr_dn2, cnt_up, cnt_dn;

  // Flags and pointer arithmetic
  always_comb begin
    posx     = XW'(pos_q);
    cntx     = XW'(cnt_q);
    full     = (cnt_q == CW'(CAPACITY));
    empty    = (cnt_q == '0);
    pos_over = (posx > cntx);
    pos_out  = (posx >= cntx);
    less     = (mem_rd_data_i < val_q);
    ptr_up   = ptr_q + CW'(1);
    ptr_up2  = ptr_q + CW'(2);
    ptr_dn   = ptr_q - CW'(1);
    ptr_dn2  = ptr_q - CW'(2);
    cnt_up   = cnt_q + CW'(1);
    cnt_dn   = cnt_q - CW'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        case (op_q)
          OP_APPEND:         state_d = ST_EMIT;
          OP_INSERT_AT:      state_d = (full || pos_over) ? ST_EMIT : ST_SHR_START;
          OP_INSERT_SORTED:  state_d = full ? ST_EMIT : (empty ? ST_SHR_START : ST_SRCH);
          OP_DELETE_LAST:    state_d = empty ? ST_EMIT : ST_LAST;
          OP_DELETE_SWAP:    state_d = (empty || pos_out) ? ST_EMIT : ST_SWP_REM;
          OP_DELETE_ORDERED: state_d = (empty || pos_out) ? ST_EMIT : ST_DEL_REM;
          OP_CLEAR:          state_d = ST_EMIT;
          OP_DUMP:           state_d = empty ? ST_EMIT : ST_DUMP;
          default:           state_d = ST_EMIT;
        endcase
      end
      ST_SHR_START: begin
        state_d = (ptr_q == tgt_q) ? ST_INS_WR : ST_SHR;
      end
      ST_SHR: begin
        if (ptr_dn == tgt_q) state_d = ST_INS_WR;
      end
      ST_INS_WR:  state_d = ST_EMIT;
      ST_SRCH: begin
        if (!less || (ptr_up == cnt_q)) state_d = ST_SHR_START;
      end
      ST_DEL_REM: begin
        state_d = (ptr_up == cnt_q) ? ST_EMIT : ST_SHL;
      end
      ST_SHL: begin
        if (ptr_up2 == cnt_q) state_d = ST_EMIT;
      end
      ST_SWP_REM: state_d = ST_SWP_WR;
      ST_SWP_WR:  state_d = ST_EMIT;
      ST_LAST:    state_d = ST_EMIT;
      ST_DUMP: begin
        if (out_free_i && (ptr_up == cnt_q)) state_d = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    op_d          = op_q;
    val_d         = val_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    ptr_d         = ptr_q;
    tgt_d         = tgt_q;
    rstat_d       = rstat_q;
    ridx_d        = ridx_q;
    relem_d       = relem_q;
    in_ready_o    = 1'b0;
    mem_we_o      = 1'b0;
    mem_wr_addr_o = AW'(ptr_q);
    mem_wr_data_o = mem_rd_data_i;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = AW'(ptr_q);
    emit_o        = 1'b0;
    res_o.status  = rstat_q;
    res_o.count   = CNT_O_W'(cnt_q);
    res_o.index   = IDX_O_W'(ridx_q);
    res_o.element = relem_q;
    res_o.last    = 1'b1;

    case (state_q)
      // Take a request word
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = in_op_i;
          val_d = in_value_i;
          pos_d = in_position_i;
        end
      end

      // Check bounds and set up the walk
      ST_DECIDE: begin
        rstat_d = STAT_OK;
        ridx_d  = '0;
        relem_d = '0;
        case (op_q)
          OP_APPEND: begin
            if (full) begin
              rstat_d = STAT_FULL;
            end else begin
              mem_we_o      = 1'b1;
              mem_wr_addr_o = AW'(cnt_q);
              mem_wr_data_o = val_q;
              cnt_d         = cnt_up;
              ridx_d        = AW'(cnt_q);
              relem_d       = val_q;
            end
          end
          OP_INSERT_AT: begin
            if (full) begin
              rstat_d = STAT_FULL;
            end else if (pos_over) begin
              rstat_d = STAT_RANGE;
            end else begin
              tgt_d = CW'(pos_q);
              ptr_d = cnt_q;
            end
          end
          OP_INSERT_SORTED: begin
            if (full) begin
              rstat_d = STAT_FULL;
            end else if (empty) begin
              tgt_d = '0;
              ptr_d = cnt_q;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = '0;
              ptr_d         = '0;
            end
          end
          OP_DELETE_LAST: begin
            if (empty) begin
              rstat_d = STAT_EMPTY;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = AW'(cnt_dn);
            end
          end
          OP_DELETE_SWAP, OP_DELETE_ORDERED: begin
            if (empty) begin
              rstat_d = STAT_EMPTY;
            end else if (pos_out) begin
              rstat_d = STAT_RANGE;
            end else begin
              tgt_d         = CW'(pos_q);
              ptr_d         = CW'(pos_q);
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = AW'(pos_q);
            end
          end
          OP_CLEAR: begin
            cnt_d = '0;
          end
          OP_DUMP: begin
            if (empty) begin
              rstat_d = STAT_EMPTY;
            end else begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = '0;
              ptr_d         = '0;
            end
          end
          default: rstat_d = STAT_OK;
        endcase
      end

      // Prime the right shift with the slot below the top
      ST_SHR_START: begin
        if (ptr_q != tgt_q) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = AW'(ptr_dn);
        end
      end

      // Move one entry up a slot per cycle, walking down
      ST_SHR: begin
        mem_we_o      = 1'b1;
        mem_wr_addr_o = AW'(ptr_q);
        ptr_d         = ptr_dn;
        if (ptr_dn != tgt_q) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = AW'(ptr_dn2);
        end
      end

      // Drop the new value into the opened slot
      ST_INS_WR: begin
        mem_we_o      = 1'b1;
        mem_wr_addr_o = AW'(tgt_q);
        mem_wr_data_o = val_q;
        cnt_d         = cnt_up;
        rstat_d       = STAT_OK;
        ridx_d        = AW'(tgt_q);
        relem_d       = val_q;
      end

      // Find the first entry not less than the new value
      ST_SRCH: begin
        if (less) begin
          if (ptr_up == cnt_q) begin
            tgt_d = cnt_q;
            ptr_d = cnt_q;
          end else begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = AW'(ptr_up);
            ptr_d         = ptr_up;
          end
        end else begin
          tgt_d = ptr_q;
          ptr_d = cnt_q;
        end
      end

      // Capture the removed entry, then start the left shift
      ST_DEL_REM: begin
        relem_d = mem_rd_data_i;
        ridx_d  = AW'(tgt_q);
        rstat_d = STAT_OK;
        if (ptr_up == cnt_q) begin
          cnt_d = cnt_dn;
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = AW'(ptr_up);
        end
      end

      // Move one entry down a slot per cycle, walking up
      ST_SHL: begin
        mem_we_o      = 1'b1;
        mem_wr_addr_o = AW'(ptr_q);
        ptr_d         = ptr_up;
        if (ptr_up2 == cnt_q) begin
          cnt_d = cnt_dn;
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = AW'(ptr_up2);
        end
      end

      // Capture the removed entry and fetch the last one
      ST_SWP_REM: begin
        relem_d       = mem_rd_data_i;
        ridx_d        = AW'(tgt_q);
        rstat_d       = STAT_OK;
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = AW'(cnt_dn);
      end

      // Fill the hole with the last entry
      ST_SWP_WR: begin
        mem_we_o      = 1'b1;
        mem_wr_addr_o = AW'(tgt_q);
        cnt_d         = cnt_dn;
      end

      // Pop the last entry
      ST_LAST: begin
        cnt_d   = cnt_dn;
        rstat_d = STAT_OK;
        ridx_d  = AW'(cnt_dn);
        relem_d = mem_rd_data_i;
      end

      // Stream every entry, one word per free output slot
      ST_DUMP: begin
        res_o.status  = STAT_OK;
        res_o.index   = IDX_O_W'(ptr_q);
        res_o.element = mem_rd_data_i;
        res_o.last    = (ptr_up == cnt_q);
        if (out_free_i) begin
          emit_o = 1'b1;
          if (ptr_up != cnt_q) begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = AW'(ptr_up);
            ptr_d         = ptr_up;
          end
        end
      end

      // Hand out the single result word
      ST_EMIT: begin
        emit_o = out_free_i;
      end

      default: emit_o = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      tgt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      tgt_q   <= tgt_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    pos_q   <= pos_d;
    rstat_q <= rstat_d;
    ridx_q  <= ridx_d;
    relem_q <= relem_d;
  end

endmodule : ibv_ctrl

`default_nettype wire

// ----- src/bounded_int_vector_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_int_vector_engine: fixed-capacity vector of signed 32-bit integers
//
// Requests enter on the s_axis channel: tuser carries the operation, tdata
// the value and the position. Results leave on the m_axis channel: tuser
// carries the status, tdata the count, index and element, tlast marks the
// final word of a request. Every request gives one word, except a dump of a
// non-empty vector, which gives one word per stored entry.
// One request is worked at a time; s_axis_tready is high only between
// requests. Insert at and sorted insert shift the entries above the slot up
// (sorted insert first compares entries from the bottom), delete ordered
// shifts the entries above the hole down, and a dump reads every entry in
// order. The walks run through one store port pair and one pointer, one
// slot per cycle, a dump only while the output register is free.
// Reset empties the vector; stored values are not cleared. A stalled
// receiver holds the output register, and the sequencer waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_int_vector_engine #(
  parameter int CAPACITY = ibv_pkg::DEF_CAPACITY
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // value [31:0], position [37:32]
  input  wire logic [ibv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation [2:0]
  input  wire logic [ibv_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // count [5:0], index [10:6], element [42:11]
  output logic [ibv_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // status [1:0]
  output logic [ibv_pkg::STAT_W-1:0]           m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import ibv_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                    out_free, emit;
  res_t                    res, m_res_q;
  logic                    m_valid_q, m_valid_d;
  logic                    mem_we, mem_rd_en;
  logic [AW-1:0]           mem_wr_addr, mem_rd_addr;
  logic signed [VAL_W-1:0] mem_wr_data, mem_rd_data;

  assign out_free = !m_valid_q || m_axis_tready;

  ibv_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (op_e'(s_axis_tuser)),
    .in_value_i    (s_axis_tdata[VAL_W-1:0]),
    .in_position_i (s_axis_tdata[VAL_W+POS_W-1:VAL_W]),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  ibv_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Output word valid: set on a new word, drop once taken
  always_comb begin
    m_valid_d = m_valid_q;
    if (emit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // Output word payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tlast  = m_res_q.last;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), m_res_q.element,
                          m_res_q.index, m_res_q.count};

endmodule : bounded_int_vector_engine

`default_nettype wire

// ----- sim/bounded_int_vector_engine_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_int_vector_engine_tb: self-checking bench for the bounded vector
//
// A driver sends request words from a queue, a monitor takes result words
// with a randomly stalled tready. Each accepted request runs through a
// behavioural copy of the vector, which queues the words it should produce.
// Every result word is checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bounded_int_vector_engine_tb;

  import ibv_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int IDLE_PCT = 29;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 2 * CAPACITY;

  // One request word, or a marker that holds the sender until all words are in
  typedef struct {
    op_e                op;
    logic signed [31:0] value;
    logic [5:0]         position;
    bit                 pause;
  } vec_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // value [31:0], position [37:32]
  logic [OP_W-1:0]       s_axis_tuser = '0;   // operation [2:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // count [5:0], index [10:6], element [42:11]
  logic [STAT_W-1:0]     m_axis_tuser;        // status [1:0]
  logic                  m_axis_tlast;

  vec_req_t           requests_pending[$];
  vec_req_t           held_req;
  res_t               words_due[$];
  logic signed [31:0] vec_slots [CAPACITY];
  int                 vec_len = 0;
  int                 accepted = 0;
  int                 mismatches = 0;
  bit                 calm;

  bounded_int_vector_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // No idling on either side for a stretch in the middle of the run
  assign calm = (accepted >= 150) && (accepted < 200);

  // --------------------------------------------------------------------------
  // Vector model
  // --------------------------------------------------------------------------

  // Queue one result word; count is the length after the request
  function automatic void note_word(stat_e st, int idx, logic signed [31:0] elem,
                                    logic lst);
    res_t w;
    w.status  = st;
    w.count   = 6'(vec_len);
    w.index   = 5'(idx);
    w.element = elem;
    w.last    = lst;
    words_due.push_back(w);
  endfunction

  // Move entries from slot at upwards one place right and grow
  function automatic void open_slot(int at);
    for (int i = vec_len; i > at; i--) vec_slots[i] = vec_slots[i-1];
    vec_len++;
  endfunction

  function automatic void predict_vector_words(vec_req_t r);
    int                 slot;
    logic signed [31:0] gone;
    case (r.op)
      OP_APPEND, OP_INSERT_AT, OP_INSERT_SORTED: begin
        if (vec_len >= CAPACITY) begin
          note_word(STAT_FULL, 0, 0, 1'b1);
        end else if (r.op == OP_INSERT_AT && int'(r.position) > vec_len) begin
          note_word(STAT_RANGE, 0, 0, 1'b1);
        end else begin
          if (r.op == OP_APPEND) begin
            slot = vec_len;
          end else if (r.op == OP_INSERT_AT) begin
            slot = int'(r.position);
          end else begin
            // first slot whose entry is not less than the new value
            slot = 0;
            while (slot < vec_len && vec_slots[slot] < r.value) slot++;
          end
          open_slot(slot);
          vec_slots[slot] = r.value;
          note_word(STAT_OK, slot, r.value, 1'b1);
        end
      end
      OP_DELETE_LAST: begin
        if (vec_len == 0) begin
          note_word(STAT_EMPTY, 0, 0, 1'b1);
        end else begin
          vec_len--;
          note_word(STAT_OK, vec_len, vec_slots[vec_len], 1'b1);
        end
      end
      OP_DELETE_SWAP, OP_DELETE_ORDERED: begin
        if (vec_len == 0) begin
          note_word(STAT_EMPTY, 0, 0, 1'b1);
        end else if (int'(r.position) >= vec_len) begin
          note_word(STAT_RANGE, 0, 0, 1'b1);
        end else begin
          slot = int'(r.position);
          gone = vec_slots[slot];
          if (r.op == OP_DELETE_SWAP) begin
            vec_slots[slot] = vec_slots[vec_len-1];
          end else begin
            for (int i = slot; i + 1 < vec_len; i++) vec_slots[i] = vec_slots[i+1];
          end
          vec_len--;
          note_word(STAT_OK, slot, gone, 1'b1);
        end
      end
      OP_CLEAR: begin
        vec_len = 0;
        note_word(STAT_OK, 0, 0, 1'b1);
      end
      OP_DUMP: begin
        if (vec_len == 0) begin
          note_word(STAT_EMPTY, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < vec_len; i++)
            note_word(STAT_OK, i, vec_slots[i], i == vec_len - 1);
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_req(op_e op, logic signed [31:0] v, logic [5:0] p);
    vec_req_t r;
    r.op       = op;
    r.value    = v;
    r.position = p;
    r.pause    = 1'b0;
    requests_pending.push_back(r);
  endtask

  task automatic add_pause();
    vec_req_t r;
    r.op       = OP_DUMP;
    r.value    = '0;
    r.position = '0;
    r.pause    = 1'b1;
    requests_pending.push_back(r);
  endtask

  // Mostly random, some small values to force ties, some extremes
  function automatic logic signed [31:0] pick_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom;
    if (pick < 85) return $urandom_range(0, 16) - 8;
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  // Low slots hit live entries, the full field reaches out of range
  function automatic logic [5:0] pick_position();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return 6'($urandom_range(0, 4));
    if (pick < 85) return 6'($urandom_range(0, CAPACITY));
    return 6'($urandom_range(0, 63));
  endfunction

  // grow: mostly inserts, shrink: mostly deletes, otherwise any request
  function automatic op_e pick_op(int mode);
    int pick;
    pick = $urandom_range(0, 99);
    if (mode == 0 && pick < 85) begin
      if (pick < 35) return OP_APPEND;
      if (pick < 65) return OP_INSERT_SORTED;
      return OP_INSERT_AT;
    end
    if (mode == 1 && pick < 85) begin
      if (pick < 25) return OP_DELETE_LAST;
      if (pick < 55) return OP_DELETE_SWAP;
      return OP_DELETE_ORDERED;
    end
    return op_e'($urandom_range(0, 7));
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    logic go;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // word taken: work out what it should produce
      if (s_axis_tvalid && s_axis_tready) begin
        predict_vector_words(held_req);
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        // drop a pause marker once every word is in
        if (requests_pending.size() > 0 && requests_pending[0].pause &&
            words_due.size() == 0)
          void'(requests_pending.pop_front());
        go = requests_pending.size() > 0 && !requests_pending[0].pause &&
             (calm || $urandom_range(0, 99) >= IDLE_PCT);
        if (go) begin
          held_req = requests_pending.pop_front();
          s_axis_tdata <= IN_DATA_W'({held_req.position, held_req.value});
          s_axis_tuser <= held_req.op;
        end
        s_axis_tvalid <= go;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got,
                             inout bit bad);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin : watch
    res_t want;
    bit   bad;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_due.size() == 0) begin
          $error("result word with none expected: tuser 0x%0h tdata 0x%0h",
                 m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = words_due.pop_front();
          bad  = 1'b0;
          check_field("status", 32'(want.status), 32'(m_axis_tuser), bad);
          check_field("count", 32'(want.count), 32'(m_axis_tdata[5:0]), bad);
          check_field("index", 32'(want.index), 32'(m_axis_tdata[10:6]), bad);
          check_field("element", want.element, m_axis_tdata[42:11], bad);
          check_field("last", 32'(want.last), 32'(m_axis_tlast), bad);
          if (bad) mismatches++;
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int made;
    int mode;
    int run_len;

    // Flagged requests on an empty vector
    add_req(OP_DUMP, 32'sd0, 6'd0);
    add_req(OP_DELETE_LAST, 32'sd0, 6'd0);
    add_req(OP_DELETE_SWAP, 32'sd0, 6'd0);
    add_req(OP_DELETE_ORDERED, 32'sd0, 6'd5);
    add_req(OP_INSERT_AT, 32'sd7, 6'd1);
    // Extremes and ties for the inserts
    add_req(OP_INSERT_AT, 32'sh8000_0000, 6'd0);
    add_req(OP_APPEND, 32'sh7FFF_FFFF, 6'd0);
    add_req(OP_INSERT_SORTED, -32'sd1, 6'd0);
    add_req(OP_INSERT_SORTED, 32'sh7FFF_FFFF, 6'd0);
    add_req(OP_INSERT_SORTED, 32'sh8000_0000, 6'd0);
    add_req(OP_INSERT_AT, 32'sh5A5A_5A5A, 6'd5);    // position equal to count
    add_req(OP_INSERT_AT, 32'sh1234_5678, 6'd63);
    add_req(OP_INSERT_AT, 32'sd0, 6'd2);
    add_req(OP_DUMP, 32'sd0, 6'd0);
    // Deletes, in range and beyond
    add_req(OP_DELETE_SWAP, 32'sd0, 6'd1);
    add_req(OP_DELETE_SWAP, 32'sd0, 6'd63);
    add_req(OP_DELETE_ORDERED, 32'sd0, 6'd0);
    add_req(OP_DELETE_ORDERED, 32'sd0, 6'd5);       // position equal to count
    add_req(OP_DELETE_SWAP, 32'sd0, 6'd4);          // last slot
    add_req(OP_DELETE_LAST, 32'sd0, 6'd0);
    add_pause();
    add_req(OP_CLEAR, 32'sd0, 6'd0);
    add_req(OP_DUMP, 32'sd0, 6'd0);
    add_req(OP_APPEND, 32'sd0, 6'd0);

    // Random runs that fill the vector up, drain it, or mix everything
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 2);
      run_len = (mode == 0) ? $urandom_range(34, 44) : $urandom_range(10, 40);
      for (int i = 0; i < run_len; i++)
        add_req(pick_op(mode), pick_value(), pick_position());
      if ($urandom_range(0, 1)) add_req(OP_DUMP, pick_value(), pick_position());
      if ($urandom_range(0, 5) == 0) add_req(OP_CLEAR, pick_value(), pick_position());
      if ($urandom_range(0, 3) == 0) add_pause();
      made += run_len + 1;
    end

    // Reset
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go in and every word to come out
    while (requests_pending.size() != 0 || s_axis_tvalid || words_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && words_due.size() == 0) begin
      $display("bounded_int_vector_engine_tb passed");
    end else begin
      $display("bounded_int_vector_engine_tb failed");
    end
    $finish;
  end

  // Hard stop
  initial begin : watchdog
    #4_000_000;
    $display("bounded_int_vector_engine_tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ibv_pkg.sv
src/ibv_mem.sv
src/ibv_ctrl.sv
src/bounded_int_vector_engine.sv
sim/bounded_int_vector_engine_tb.sv
